>>> rtl/core/km1d_pkg.sv
// km1d_pkg: shared types, constants and command/status structs for the 1-D k-means block.
// No dependencies.
package km1d_pkg;

   localparam int SampleBits  = 16;
   localparam int FracBits    = 8;
   localparam int MeanBits    = SampleBits + FracBits;
   localparam int MaxSamples  = 1024;
   localparam int AddrBits    = $clog2(MaxSamples);
   localparam int CountBits   = AddrBits + 1;
   localparam int MaxMeans    = 8;
   localparam int IdxBits     = $clog2(MaxMeans);
   localparam int NBits       = IdxBits + 1;
   localparam int MaxSteps    = 100;
   localparam int StepBits    = 7;
   localparam int SumBits     = SampleBits + AddrBits;
   localparam int DivBits     = SumBits + FracBits;

   localparam logic [1:0] OP_LOAD     = 2'd0;
   localparam logic [1:0] OP_CLASSIFY = 2'd1;
   localparam logic [1:0] OP_WRITE    = 2'd2;

   typedef struct packed {
      logic [1:0]            opcode;
      logic [SampleBits-1:0] sample_value;
      logic [2:0]            mean_index;
      logic [MeanBits-1:0]   mean_value;
      logic                  last;
   } req_type;

   typedef struct packed {
      logic [2:0]          cluster_index;
      logic [MeanBits-1:0] mean_out;
      logic [6:0]          steps_taken;
      logic                converged;
      logic                final_item;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic store_sample;   // write sample, update min/max/count
      logic clr_count;
      logic write_mean;
      logic cls_start;      // scan the n_use active means against smp_ff
      logic sp_start;       // re-spread one mean (index from sel)
      logic step_clear;     // zero sums/counts, snapshot means
      logic rd_issue;       // read sample at addr
      logic acc_en;         // assign read sample (pipelined)
      logic upd_start;      // start divide for mean sel
      logic [IdxBits-1:0] sel;
      logic [AddrBits-1:0] addr;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic                 nearest_done;
      logic                 div_done;
      logic                 changed;
      logic [CountBits-1:0] sample_count;
   } sts_type;

endpackage

>>> rtl/core/km1d_ram.sv
// km1d_ram: generic single-port-write, registered-read RAM.
// No dependencies.
module km1d_ram #(
   parameter int Width = 16,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

>>> rtl/core/km1d_div.sv
// km1d_div: restoring divider, one quotient bit per cycle.
// Depends on km1d_pkg.
module km1d_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [km1d_pkg::DivBits-1:0]    dividend,
   input  logic [km1d_pkg::CountBits-1:0]  divisor,
   output logic                            done,
   output logic [km1d_pkg::DivBits-1:0]    quotient
);
   import km1d_pkg::*;
   localparam int CntW = $clog2(DivBits + 1);
   logic [DivBits-1:0] q_ff, q_in;
   logic [CountBits:0] r_ff, r_in;
   logic [CountBits-1:0] d_ff, d_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [CountBits:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[CountBits-1:0], q_ff[DivBits-1]};
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor;
         cnt_in = CntW'(DivBits); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[DivBits-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[DivBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end
   assign done = done_ff;
   assign quotient = q_ff;
endmodule

>>> rtl/core/km1d_datapath.sv
// km1d_datapath: sample store, means, min/max, nearest-mean scan, accumulators, divider.
// Depends on km1d_pkg, km1d_ram, km1d_div.
module km1d_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  km1d_pkg::cmd_type                cmd,
   input  km1d_pkg::req_type                req,
   input  logic [km1d_pkg::NBits-1:0]       n_use,
   output km1d_pkg::sts_type                sts,
   output logic [km1d_pkg::IdxBits-1:0]     near_idx,
   output logic [km1d_pkg::MeanBits-1:0]    mean_sel
);
   import km1d_pkg::*;

   logic [MeanBits-1:0] means_ff [MaxMeans];
   logic [MeanBits-1:0] prev_ff [MaxMeans];
   logic [SumBits-1:0]  sums_ff [MaxMeans];
   logic [CountBits-1:0] cnts_ff [MaxMeans];
   logic [SampleBits-1:0] min_ff, max_ff;
   logic [CountBits-1:0] count_ff;
   logic [SampleBits-1:0] rd_data;
   logic [SampleBits-1:0] smp_ff;

   // nearest scan: one mean per cycle
   logic                scan_ff;
   logic [IdxBits-1:0]  scan_m_ff;
   logic [IdxBits-1:0]  best_ff;
   logic [MeanBits-1:0] bestd_ff;
   logic                ndone_ff;
   logic                scan_acc_ff;   // scan result feeds accumulators
   logic [MeanBits-1:0] fs, mv, gap;
   logic                chg_ff;
   logic                div_done;
   logic [DivBits-1:0]  quot;
   logic [DivBits-1:0]  dividend;
   logic [IdxBits-1:0]  upd_ff;

   // re-spread path: product is combinational, loaded into the divider, then divide by n-1
   logic [MeanBits-1:0] lo, hi;
   logic [MeanBits+IdxBits-1:0] prod;

   km1d_ram #(.Width(SampleBits), .Depth(MaxSamples)) u_store (
      .clock(clock),
      .wr_en(cmd.store_sample && count_ff < CountBits'(MaxSamples)),
      .wr_addr(count_ff[AddrBits-1:0]),
      .wr_data(req.sample_value),
      .rd_addr(cmd.addr),
      .rd_data(rd_data)
   );

   assign dividend = cmd.sp_start
      ? DivBits'(prod)
      : DivBits'({sums_ff[cmd.sel], {FracBits{1'b0}}});

   km1d_div u_div (
      .clock(clock), .reset(reset),
      .start(cmd.upd_start || cmd.sp_start),
      .dividend(dividend),
      .divisor(cmd.sp_start ? CountBits'(n_use - 1'b1) : cnts_ff[cmd.sel]),
      .done(div_done), .quotient(quot)
   );

   assign lo = {min_ff, {FracBits{1'b0}}};
   assign hi = {max_ff, {FracBits{1'b0}}};
   assign prod = (hi - lo) * cmd.sel;
   assign fs = {smp_ff, {FracBits{1'b0}}};
   assign mv = means_ff[scan_m_ff];
   assign gap = (fs > mv) ? fs - mv : mv - fs;

   logic sp_ff;
   always_ff @(posedge clock) begin
      if (cmd.store_sample || cmd.cls_start) smp_ff <= req.sample_value;
      else if (cmd.acc_en) smp_ff <= rd_data;
      if (cmd.step_clear) begin
         for (int i = 0; i < MaxMeans; i++) begin
            prev_ff[i] <= means_ff[i];
            sums_ff[i] <= '0;
            cnts_ff[i] <= '0;
         end
      end
      if (cmd.upd_start || cmd.sp_start) upd_ff <= cmd.sel;
      if (scan_ff) begin
         if (scan_m_ff == '0 || gap <= bestd_ff) begin
            bestd_ff <= gap; best_ff <= scan_m_ff;
         end
      end
      if (ndone_ff && scan_acc_ff) begin
         sums_ff[best_ff] <= sums_ff[best_ff] + SumBits'(smp_ff);
         cnts_ff[best_ff] <= cnts_ff[best_ff] + 1'b1;
      end
      if (reset) begin
         count_ff <= '0; min_ff <= '0; max_ff <= '0;
         for (int i = 0; i < MaxMeans; i++) means_ff[i] <= '0;
         scan_ff <= 1'b0; ndone_ff <= 1'b0; scan_acc_ff <= 1'b0;
         scan_m_ff <= '0; chg_ff <= 1'b0; sp_ff <= 1'b0;
      end else begin
         if (cmd.store_sample && count_ff < CountBits'(MaxSamples)) begin
            if (count_ff == '0 || req.sample_value < min_ff) min_ff <= req.sample_value;
            if (count_ff == '0 || req.sample_value > max_ff) max_ff <= req.sample_value;
         end
         if (cmd.clr_count) count_ff <= '0;
         else if (cmd.store_sample && count_ff < CountBits'(MaxSamples))
            count_ff <= count_ff + 1'b1;
         if (cmd.write_mean) means_ff[req.mean_index] <= req.mean_value;
         ndone_ff <= 1'b0;
         if (cmd.cls_start || cmd.acc_en) begin
            scan_ff <= 1'b1; scan_m_ff <= '0; scan_acc_ff <= cmd.acc_en;
         end else if (scan_ff) begin
            if (NBits'(scan_m_ff) + 1'b1 >= n_use) begin
               scan_ff <= 1'b0; ndone_ff <= 1'b1;
            end else begin
               scan_m_ff <= scan_m_ff + 1'b1;
            end
         end
         if (cmd.step_clear) chg_ff <= 1'b0;
         if (cmd.sp_start) sp_ff <= 1'b1;
         else if (cmd.upd_start) sp_ff <= 1'b0;
         if (div_done) begin
            if (sp_ff) begin
               if (!(means_ff[upd_ff] > lo && means_ff[upd_ff] < hi))
                  means_ff[upd_ff] <= (n_use == NBits'(1)) ? lo
                                      : lo + MeanBits'(quot);
            end else if (cnts_ff[upd_ff] != '0) begin
               means_ff[upd_ff] <= MeanBits'(quot);
               if (MeanBits'(quot) != prev_ff[upd_ff]) chg_ff <= 1'b1;
            end
         end
      end
   end

   assign sts.nearest_done = ndone_ff;
   assign sts.div_done = div_done;
   assign sts.changed = chg_ff;
   assign sts.sample_count = count_ff;
   assign near_idx = best_ff;
   assign mean_sel = means_ff[cmd.sel];
endmodule

>>> rtl/core/km1d_ctrl.sv
// km1d_ctrl: controller state machine sequencing load, write, classify, re-spread, steps and emit.
// Depends on km1d_pkg.
module km1d_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  km1d_pkg::req_type             req,
   input  logic [km1d_pkg::NBits-1:0]    n_use,
   input  km1d_pkg::sts_type             sts,
   input  logic [km1d_pkg::IdxBits-1:0]  near_idx,
   input  logic [km1d_pkg::MeanBits-1:0] mean_sel,
   output km1d_pkg::cmd_type             cmd,
   output logic                          busy,
   output logic                          rsp_valid,
   output km1d_pkg::rsp_type             rsp_data
);
   import km1d_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_CLS = 4'd1, S_SP = 4'd2, S_SPW = 4'd3,
      S_CLR = 4'd4, S_RD = 4'd5, S_ACC = 4'd6, S_ACCW = 4'd7, S_UPD = 4'd8,
      S_UPDW = 4'd9, S_CHK = 4'd10, S_EMIT = 4'd11, S_SP0 = 4'd12;

   logic [3:0] st_ff, st_in;
   logic [IdxBits-1:0] m_ff, m_in;
   logic [AddrBits-1:0] a_ff, a_in;
   logic [StepBits-1:0] steps_ff, steps_in;
   logic conv_ff, conv_in;
   logic vld_ff, vld_in;
   rsp_type rsp_ff, rsp_in;
   logic acc;

   assign acc = start && !busy;

   always_comb begin
      st_in = st_ff; m_in = m_ff; a_in = a_ff; steps_in = steps_ff;
      conv_in = conv_ff; vld_in = 1'b0; rsp_in = rsp_ff;
      cmd = '0;
      cmd.sel = m_ff;
      cmd.addr = a_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (acc) begin
               unique case (req.opcode)
                  OP_LOAD: begin
                     cmd.store_sample = 1'b1;
                     if (req.last) begin
                        st_in = S_SP0; m_in = '0;
                     end
                  end
                  OP_CLASSIFY: begin
                     cmd.cls_start = 1'b1; st_in = S_CLS;
                  end
                  OP_WRITE: cmd.write_mean = 1'b1;
                  default: ;
               endcase
            end
         end
         S_CLS: if (sts.nearest_done) begin
            cmd.sel = near_idx;
            rsp_in = '{near_idx, mean_sel, 7'd0, 1'b0, 1'b1};
            vld_in = 1'b1; st_in = S_IDLE;
         end
         S_SP0: begin
            steps_in = '0; conv_in = 1'b0;
            st_in = (sts.sample_count == '0) ? S_CLR : S_SP;
         end
         S_SP: begin
            cmd.sp_start = 1'b1; st_in = S_SPW;
         end
         S_SPW: if (sts.div_done) begin
            if (NBits'(m_ff) + 1'b1 >= n_use) begin
               m_in = '0; st_in = S_CLR;
            end else begin
               m_in = m_ff + 1'b1; st_in = S_SP;
            end
         end
         S_CLR: begin
            cmd.step_clear = 1'b1; a_in = '0;
            steps_in = steps_ff + 1'b1; st_in = S_RD;
         end
         S_RD: begin
            cmd.rd_issue = 1'b1; st_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc_en = 1'b1; st_in = S_ACCW;
         end
         S_ACCW: if (sts.nearest_done) begin
            if (CountBits'(a_ff) + 1'b1 >= sts.sample_count) begin
               m_in = '0; st_in = S_UPD;
            end else begin
               a_in = a_ff + 1'b1; st_in = S_RD;
            end
         end
         S_UPD: begin
            cmd.upd_start = 1'b1; st_in = S_UPDW;
         end
         S_UPDW: if (sts.div_done) begin
            if (NBits'(m_ff) + 1'b1 >= n_use) begin
               m_in = '0; st_in = S_CHK;
            end else begin
               m_in = m_ff + 1'b1; st_in = S_UPD;
            end
         end
         S_CHK: begin
            if (!sts.changed) begin
               conv_in = 1'b1; st_in = S_EMIT;
            end else if (steps_ff >= StepBits'(MaxSteps)) st_in = S_EMIT;
            else st_in = S_CLR;
         end
         S_EMIT: begin
            vld_in = 1'b1;
            rsp_in = '{m_ff, mean_sel, steps_ff, conv_ff,
                       NBits'(m_ff) + 1'b1 >= n_use};
            if (NBits'(m_ff) + 1'b1 >= n_use) begin
               cmd.clr_count = 1'b1; st_in = S_IDLE;
            end else m_in = m_ff + 1'b1;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in; a_ff <= a_in; steps_ff <= steps_in;
      conv_ff <= conv_in; rsp_ff <= rsp_in;
      if (reset) begin
         st_ff <= S_IDLE; vld_ff <= 1'b0;
      end else begin
         st_ff <= st_in; vld_ff <= vld_in;
      end
   end

   assign busy = (st_ff != S_IDLE);
   assign rsp_valid = vld_ff;
   assign rsp_data = rsp_ff;
endmodule

>>> rtl/core/kmeans_1d_clusterer_top.sv
// kmeans_1d_clusterer_top: 1-D k-means block, controller plus datapath.
// Run length is set by the one-mean-per-cycle scan and the 34-bit divider.
// Throughput: one load per cycle while idle; results one per cycle, cannot be stalled.
// Reset (synchronous): means, count, min, max cleared, mean_count=2; sample RAM needs no clear.
// Depends on km1d_pkg, km1d_ctrl, km1d_datapath.
module kmeans_1d_clusterer_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  km1d_pkg::req_type    req_data,
   output logic                 rsp_strobe,
   output km1d_pkg::rsp_type    rsp_data,
   input  logic                 csr_wr_en,
   input  logic [3:0]           csr_wr_data
);
   import km1d_pkg::*;

   logic [3:0] mc_ff;
   logic [NBits-1:0] n_use;
   cmd_type cmd;
   sts_type sts;
   logic [IdxBits-1:0] near_idx;
   logic [MeanBits-1:0] mean_sel;

   // mean_count register; 0 clamps to 1, above MaxMeans clamps to MaxMeans
   always_ff @(posedge clock) begin
      if (reset) mc_ff <= 4'd2;
      else if (csr_wr_en) mc_ff <= csr_wr_data;
   end
   assign n_use = (mc_ff == 4'd0) ? NBits'(1)
                : (mc_ff > 4'(MaxMeans)) ? NBits'(MaxMeans) : NBits'(mc_ff);

   km1d_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req(req_data),
      .n_use(n_use), .sts(sts), .near_idx(near_idx), .mean_sel(mean_sel),
      .cmd(cmd), .busy(busy), .rsp_valid(rsp_strobe), .rsp_data(rsp_data)
   );

   km1d_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req(req_data), .n_use(n_use),
      .sts(sts), .near_idx(near_idx), .mean_sel(mean_sel)
   );

`ifndef SYNTH
   // classify result always marks final item and carries no step count
   a_cls: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.steps_taken == '0 |-> rsp_data.final_item)
      else $error("classify result without final_item");
   // no result strobe when the block was idle in the previous cycle
   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result from idle");
   // emitted index stays below cluster count
   a_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> NBits'(rsp_data.cluster_index) < n_use)
      else $error("index out of range");
`endif
endmodule
